>>> rtl/fslc_pkg.sv
// Package for the flow sequence latency checker.
// Holds the word, state and result types and the codes. It depends on nothing.
`default_nettype none
package fslc_pkg;

    localparam int NUM_FLOWS = 128;
    localparam int FLOW_W    = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam logic [31:0] SEQ_RESET = 32'hFFFF_FFFE;

    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 448;

    typedef enum logic [1:0] {
        OP_PKT   = 2'd0,
        OP_STOP  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STAT_IN_ORDER = 3'd0,
        STAT_GAP      = 3'd1,
        STAT_DUP      = 3'd2,
        STAT_REORDER  = 3'd3,
        STAT_OLD_FLOW = 3'd4,
        STAT_BAD_HDR  = 3'd5,
        STAT_IGNORED  = 3'd6,
        STAT_CTRL     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAGIC    = 2'd0,
        CFG_INIT_TAG = 2'd1,
        CFG_SW_MODE  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] flow_index;
        logic [7:0]  magic;
        logic [7:0]  flow_tag;
        logic [31:0] pkt_seq;
        logic [63:0] send_time;
        logic [63:0] arrival_time;
        logic [15:0] pkt_len;
    } item_t;

    typedef struct packed {
        logic [31:0] exp_seq;
        logic [7:0]  tag_exp;
        logic [7:0]  tag_prev;
        logic [31:0] lost;
        logic [31:0] reorder;
        logic [31:0] dup;
        logic [31:0] gap_ev;
        logic [31:0] back_ev;
        logic [63:0] pkts;
        logic [63:0] bytes;
    } flow_state_t;

    localparam int STATE_W = $bits(flow_state_t);

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] gap_size;
        logic [63:0] latency_ticks;
        logic [31:0] lost_total;
        logic [31:0] reorder_total;
        logic [31:0] dup_total;
        logic [31:0] too_big_total;
        logic [31:0] too_low_total;
        logic [63:0] pkt_total;
        logic [63:0] byte_total;
        logic [31:0] bad_header_total;
        logic [31:0] old_flow_total;
    } result_t;

    typedef struct packed {
        logic  valid;
        item_t head;
    } fifo_out_t;

endpackage
`default_nettype wire

>>> rtl/fslc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fslc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/fslc_front.sv
// Front end: takes input words, unpacks them and queues them (two entries).
// Depends on fslc_pkg.
`default_nettype none
module fslc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fslc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]                      s_tuser,
    input  wire logic                            pop,
    output fslc_pkg::fifo_out_t                  fifo_out
);
    import fslc_pkg::*;

    item_t      ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    always_comb
    begin
        in_item.op           = s_tuser;
        in_item.flow_index   = s_tdata[15:0];
        in_item.magic        = s_tdata[23:16];
        in_item.flow_tag     = s_tdata[31:24];
        in_item.pkt_seq      = s_tdata[63:32];
        in_item.send_time    = s_tdata[127:64];
        in_item.arrival_time = s_tdata[191:128];
        in_item.pkt_len      = s_tdata[207:192];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign fifo_out.valid = (cnt_reg != 2'd0);
    assign fifo_out.head  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2) else $error("full queue lost entry");
`endif
endmodule
`default_nettype wire

>>> rtl/fslc_back.sv
// Back end: per-flow read-modify-write on the state RAM, global counters,
// configuration registers and the result register. Depends on fslc_pkg, fslc_ram.
`default_nettype none
module fslc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fslc_pkg::fifo_out_t  fifo_out,
    output logic                      pop,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output fslc_pkg::result_t         res
);
    import fslc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t      st_reg, st_next;
    item_t       cur_reg;
    result_t     res_reg, res_next;
    logic        m_valid_reg, m_valid_next;
    logic [NUM_FLOWS-1:0] vld_reg, vld_next;
    logic [31:0] bad_reg, bad_next, old_reg, old_next;
    logic [7:0]  magic_reg, init_tag_reg;
    logic        sw_reg;

    logic [STATE_W-1:0] rd_raw;
    flow_state_t st_cur, st_new, st_rst;
    logic        ram_we;
    logic        idx_ok;
    logic [FLOW_W-1:0] f;
    logic [31:0] diff;
    logic        good;

    assign pop     = (st_reg == ST_IDLE) && fifo_out.valid && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign res     = res_reg;
    assign idx_ok  = cur_reg.flow_index < 16'(NUM_FLOWS);
    assign f       = idx_ok ? cur_reg.flow_index[FLOW_W-1:0] : '0;

    fslc_ram #(.WIDTH(STATE_W), .DEPTH(NUM_FLOWS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (f),
        .wdata (st_new),
        .re    (pop),
        .raddr (fifo_out.head.flow_index[FLOW_W-1:0]),
        .rdata (rd_raw)
    );

    always_comb
    begin
        st_rst         = '0;
        st_rst.exp_seq = SEQ_RESET;
        st_cur = vld_reg[f] ? flow_state_t'(rd_raw) : st_rst;
        st_new = st_cur;
        diff   = cur_reg.pkt_seq - st_cur.exp_seq;
        good   = 1'b0;
        bad_next = bad_reg;
        old_next = old_reg;
        res_next = '0;
        res_next.status = STAT_IGNORED;
        ram_we = 1'b0;
        unique case (cur_reg.op)
            OP_PKT:
            begin
                if (cur_reg.magic != magic_reg || !idx_ok)
                begin
                    if (!sw_reg)
                    begin
                        bad_next = bad_reg + 32'd1;
                        res_next.status = STAT_BAD_HDR;
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                    good   = 1'b1;
                    if (cur_reg.flow_tag != st_cur.tag_exp)
                    begin
                        priority if (cur_reg.flow_tag == st_cur.tag_prev)
                        begin
                            good = 1'b0;
                            old_next = old_reg + 32'd1;
                            res_next.status = STAT_OLD_FLOW;
                        end
                        else if (st_cur.tag_exp == init_tag_reg)
                        begin
                            st_new.tag_exp = cur_reg.flow_tag;
                        end
                        else
                        begin
                            good = 1'b0;
                            bad_next = bad_reg + 32'd1;
                            res_next.status = STAT_BAD_HDR;
                        end
                    end
                    if (good)
                    begin
                        priority if (diff == 32'd0)
                        begin
                            st_new.exp_seq = cur_reg.pkt_seq + 32'd1;
                            res_next.status = STAT_IN_ORDER;
                        end
                        else if (diff[31])
                        begin
                            if (cur_reg.pkt_seq == st_cur.exp_seq - 32'd1)
                            begin
                                st_new.dup = st_cur.dup + 32'd1;
                                res_next.status = STAT_DUP;
                            end
                            else
                            begin
                                st_new.reorder = st_cur.reorder + 32'd1;
                                st_new.lost    = st_cur.lost - 32'd1;
                                res_next.status = STAT_REORDER;
                            end
                            st_new.back_ev = st_cur.back_ev + 32'd1;
                        end
                        else
                        begin
                            st_new.lost    = st_cur.lost + diff;
                            st_new.gap_ev  = st_cur.gap_ev + 32'd1;
                            st_new.exp_seq = cur_reg.pkt_seq + 32'd1;
                            res_next.gap_size = diff[30:0];
                            res_next.status = STAT_GAP;
                        end
                        st_new.pkts  = st_cur.pkts + 64'd1;
                        st_new.bytes = st_cur.bytes + {48'd0, cur_reg.pkt_len} + 64'd4;
                        res_next.latency_ticks = cur_reg.arrival_time - cur_reg.send_time;
                    end
                end
            end
            OP_STOP:
            begin
                if (idx_ok)
                begin
                    ram_we = 1'b1;
                    if (st_cur.tag_exp != init_tag_reg)
                    begin
                        st_new.tag_prev = st_cur.tag_exp;
                        st_new.tag_exp  = init_tag_reg;
                    end
                    res_next.status = STAT_CTRL;
                end
            end
            OP_CLEAR:
            begin
                if (idx_ok)
                begin
                    ram_we = 1'b1;
                    st_new = st_rst;
                    st_new.tag_exp  = st_cur.tag_exp;
                    st_new.tag_prev = st_cur.tag_prev;
                    res_next.status = STAT_CTRL;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        if (st_reg != ST_EXEC)
        begin
            ram_we = 1'b0;
        end
        if (idx_ok)
        begin
            res_next.lost_total    = st_new.lost;
            res_next.reorder_total = st_new.reorder;
            res_next.dup_total     = st_new.dup;
            res_next.too_big_total = st_new.gap_ev;
            res_next.too_low_total = st_new.back_ev;
            res_next.pkt_total     = st_new.pkts;
            res_next.byte_total    = st_new.bytes;
        end
        res_next.bad_header_total = bad_next;
        res_next.old_flow_total   = old_next;
    end

    always_comb
    begin
        st_next      = st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        vld_next     = vld_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                st_next      = ST_IDLE;
                m_valid_next = 1'b1;
                if (ram_we)
                begin
                    vld_next[f] = 1'b1;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= fifo_out.head;
        end
        if (st_reg == ST_EXEC)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            vld_reg      <= '0;
            bad_reg      <= '0;
            old_reg      <= '0;
            magic_reg    <= 8'd171;
            init_tag_reg <= 8'd0;
            sw_reg       <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
            vld_reg     <= vld_next;
            if (st_reg == ST_EXEC)
            begin
                bad_reg <= bad_next;
                old_reg <= old_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAGIC:    magic_reg    <= cfg_data;
                    CFG_INIT_TAG: init_tag_reg <= cfg_data;
                    CFG_SW_MODE:  sw_reg       <= cfg_data[0];
                    default:      sw_reg       <= sw_reg;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_exec_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_EXEC |-> $past(pop)) else $error("exec without pop");
    a_we_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> st_reg == ST_EXEC) else $error("ram write outside exec");
    a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !m_valid_reg && fifo_out.valid) else $error("pop with result pending");
    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_EXEC |=> m_valid_reg) else $error("result not posted");
`endif
endmodule
`default_nettype wire

>>> rtl/flow_sequence_latency_checker.sv
// Top level of the flow sequence latency checker.
// Depends on fslc_pkg, fslc_front, fslc_back (and fslc_ram through it).
// Path: input queue, then state RAM read, then update into the result register.
// Words go one at a time: the next leaves the queue only after the last result is taken.
// Reset: asynchronous, active low; flow state reads as its reset value through
// per-flow valid bits cleared at once, so no clearing pass is needed.
`default_nettype none
module flow_sequence_latency_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // flow_index, magic, flow_tag, pkt_seq, send_time, arrival_time, pkt_len
    input  wire logic [fslc_pkg::IN_DATA_W-1:0]   s_tdata,
    // op
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // gap_size, latency_ticks, lost_total, reorder_total, dup_total, too_big_total,
    // too_low_total, pkt_total, byte_total, bad_header_total, old_flow_total, pad
    output logic [fslc_pkg::OUT_DATA_W-1:0]       m_tdata,
    // status
    output logic [2:0]                            m_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [7:0]                       cfg_data
);
    import fslc_pkg::*;

    fifo_out_t fifo_out;
    logic      pop;
    result_t   res;

    fslc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .fifo_out (fifo_out)
    );

    fslc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_out  (fifo_out),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .res       (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {1'b0, res.old_flow_total, res.bad_header_total, res.byte_total,
                      res.pkt_total, res.too_low_total, res.too_big_total, res.dup_total,
                      res.reorder_total, res.lost_total, res.latency_ticks, res.gap_size};
endmodule
`default_nettype wire

>>> test/fslc_checker.sv
// Scoreboard for the flow sequence latency checker: predicts each result word
// from accepted input words and register writes, and compares them in order.
// Depends on fslc_pkg.
`timescale 1ns / 100ps
`default_nettype none
module fslc_checker
    import fslc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [2:0]            m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    output int                         errors,
    output int                         pending
);
    logic [7:0]  magic_reg;
    logic [7:0]  init_tag_reg;
    logic        sw_mode_reg;
    flow_state_t flows [NUM_FLOWS];
    logic [31:0] bad_hdr_cnt;
    logic [31:0] old_flow_cnt;
    result_t     expected_q [$];

    function automatic flow_state_t cleared(flow_state_t s);
        flow_state_t c;
        c = '0;
        c.exp_seq = SEQ_RESET;
        c.tag_exp = s.tag_exp;
        c.tag_prev = s.tag_prev;
        return c;
    endfunction

    task automatic predict_word(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
        logic [15:0] idx;
        logic [7:0]  mg, tg;
        logic [31:0] seq, diff;
        logic [63:0] st, at;
        logic [15:0] len;
        logic        ok, good;
        int          f;
        flow_state_t s;
        result_t     r;
        idx = d[15:0];
        mg  = d[23:16];
        tg  = d[31:24];
        seq = d[63:32];
        st  = d[127:64];
        at  = d[191:128];
        len = d[207:192];
        ok  = idx < NUM_FLOWS;
        f   = ok ? idx : 0;
        s   = flows[f];
        r   = '0;
        r.status = STAT_IGNORED;
        if (op == OP_PKT) begin
            if (mg != magic_reg || !ok) begin
                if (!sw_mode_reg) begin
                    bad_hdr_cnt++;
                    r.status = STAT_BAD_HDR;
                end
            end
            else begin
                good = 1'b1;
                if (tg != s.tag_exp) begin
                    if (tg == s.tag_prev) begin
                        good = 1'b0;
                        old_flow_cnt++;
                        r.status = STAT_OLD_FLOW;
                    end
                    else if (s.tag_exp == init_tag_reg)
                        s.tag_exp = tg;
                    else begin
                        good = 1'b0;
                        bad_hdr_cnt++;
                        r.status = STAT_BAD_HDR;
                    end
                end
                if (good) begin
                    diff = seq - s.exp_seq;
                    if (diff == 0) begin
                        s.exp_seq = seq + 1;
                        r.status = STAT_IN_ORDER;
                    end
                    else if (diff[31]) begin
                        if (seq == s.exp_seq - 32'd1) begin
                            s.dup++;
                            r.status = STAT_DUP;
                        end
                        else begin
                            s.reorder++;
                            s.lost--;
                            r.status = STAT_REORDER;
                        end
                        s.back_ev++;
                    end
                    else begin
                        s.lost += diff;
                        s.gap_ev++;
                        s.exp_seq = seq + 1;
                        r.gap_size = diff[30:0];
                        r.status = STAT_GAP;
                    end
                    s.pkts++;
                    s.bytes += 64'(len) + 64'd4;
                    r.latency_ticks = at - st;
                end
            end
        end
        else if (op == OP_STOP && ok) begin
            if (s.tag_exp != init_tag_reg) begin
                s.tag_prev = s.tag_exp;
                s.tag_exp = init_tag_reg;
            end
            r.status = STAT_CTRL;
        end
        else if (op == OP_CLEAR && ok) begin
            s = cleared(s);
            r.status = STAT_CTRL;
        end
        flows[f] = s;
        if (ok) begin
            r.lost_total    = s.lost;
            r.reorder_total = s.reorder;
            r.dup_total     = s.dup;
            r.too_big_total = s.gap_ev;
            r.too_low_total = s.back_ev;
            r.pkt_total     = s.pkts;
            r.byte_total    = s.bytes;
        end
        r.bad_header_total = bad_hdr_cnt;
        r.old_flow_total   = old_flow_cnt;
        expected_q.push_back(r);
    endtask

    task automatic compare_word();
        result_t e;
        result_t a;
        a.status = m_tuser;
        {a.old_flow_total, a.bad_header_total, a.byte_total, a.pkt_total,
         a.too_low_total, a.too_big_total, a.dup_total, a.reorder_total,
         a.lost_total, a.latency_ticks, a.gap_size} = m_tdata[446:0];
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result word: %h", a);
            return;
        end
        e = expected_q.pop_front();
        if (a != e) begin
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t:\n  exp %p\n  got %p", $time, e, a);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            magic_reg    <= 8'd171;
            init_tag_reg <= 8'd0;
            sw_mode_reg  <= 1'b0;
            bad_hdr_cnt  = '0;
            old_flow_cnt = '0;
            for (int i = 0; i < NUM_FLOWS; i++)
                flows[i] = cleared('0);
            errors = 0;
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAGIC:    magic_reg    <= cfg_data;
                    CFG_INIT_TAG: init_tag_reg <= cfg_data;
                    CFG_SW_MODE:  sw_mode_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                compare_word();
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata);
            pending <= expected_q.size();
        end
    end
endmodule
`default_nettype wire

>>> test/testbench.sv
// Stimulus and verdict for the flow sequence latency checker.
// Depends on fslc_pkg, flow_sequence_latency_checker and fslc_checker.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import fslc_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [7:0]            cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    cycles = 0;

    logic [7:0]  cur_magic;
    logic [31:0] next_seq [8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flow_sequence_latency_checker u_dut (.*);
    fslc_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // result sink stall
    initial
    begin
        @(negedge clk);
        forever
        begin
            m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 600 < 150);
            @(negedge clk);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [15:0] idx, input logic [7:0] mg,
                             input logic [7:0] tg, input logic [31:0] seq,
                             input logic [63:0] st, input logic [63:0] at,
                             input logic [15:0] len);
        int n;
        n = (cycles % 700 < 150) ? 0 : gap_len();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {len, at, st, seq, tg, mg, idx};
        #0;
        while (!s_tready) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t i, input logic [7:0] v);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= i;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (i == CFG_MAGIC) cur_magic = v;
    endtask

    task automatic random_word(input logic [7:0] tag);
        int k;
        int f;
        logic [1:0] op;
        logic [15:0] idx;
        logic [7:0] mg;
        logic [31:0] seq;
        k = $urandom_range(0, 99);
        f = $urandom_range(0, 7);
        idx = (k < 3) ? 16'($urandom) : 16'(f * 17);
        mg = (k >= 3 && k < 6) ? 8'($urandom) : cur_magic;
        op = OP_PKT;
        if (k >= 6 && k < 9) op = OP_STOP;
        else if (k >= 9 && k < 11) op = OP_CLEAR;
        else if (k == 11) op = 2'd3;
        k = $urandom_range(0, 99);
        if (k < 70) seq = next_seq[f];
        else if (k < 80) seq = next_seq[f] + $urandom_range(1, 5);
        else if (k < 87) seq = next_seq[f] - 1;
        else if (k < 95) seq = next_seq[f] - $urandom_range(2, 6);
        else seq = $urandom;
        if (op == OP_PKT && (seq - next_seq[f]) < 32'h8000_0000) next_seq[f] = seq + 1;
        if (op == OP_CLEAR) next_seq[f] = SEQ_RESET;
        send_word(op, idx, mg, ($urandom_range(0, 9) == 0) ? 8'($urandom) : tag, seq,
                  {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
    endtask

    initial
    begin
        logic [7:0] tag;
        cur_magic = 8'd171;
        foreach (next_seq[i]) next_seq[i] = SEQ_RESET;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        send_word(OP_PKT, 16'd0, 8'd171, 8'd5, SEQ_RESET, 64'd0, '1, 16'hFFFF);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd5, 32'hFFFF_FFFF, '1, 64'd0, 16'd0);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd5, 32'd0, 64'd10, 64'd3, 16'd64);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd5, 32'd0, 64'd1, 64'd2, 16'd64);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd5, 32'h7FFF_FFF0, 64'd1, 64'd2, 16'd64);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd5, 32'd3, 64'd1, 64'd2, 16'd64);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd9, 32'd3, 64'd1, 64'd2, 16'd64);
        send_word(OP_STOP, 16'd0, 8'd0, 8'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd5, 32'd3, 64'd1, 64'd2, 16'd64);
        send_word(OP_STOP, 16'd0, 8'd0, 8'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd6, 32'hFFFF_FFFF, 64'd1, 64'd2, 16'd64);
        send_word(OP_PKT, 16'd127, 8'd0, 8'd6, 32'd0, 64'd1, 64'd2, 16'd1);
        send_word(OP_PKT, 16'd128, 8'd171, 8'hFF, '1, '1, '1, '1);
        send_word(OP_PKT, 16'hFFFF, 8'd171, 8'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_CLEAR, 16'd0, 8'd0, 8'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_CLEAR, 16'd128, 8'd0, 8'd0, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_STOP, 16'hFFFF, 8'hFF, 8'hFF, '1, '1, '1, '1);
        send_word(2'd3, 16'd0, 8'd171, 8'd6, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd6, SEQ_RESET, 64'd0, 64'd0, 16'd0);
        write_reg(CFG_SW_MODE, 8'd1);
        send_word(OP_PKT, 16'd0, 8'd0, 8'd6, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_PKT, 16'd200, 8'd171, 8'd6, 32'd0, 64'd0, 64'd0, 16'd0);
        send_word(OP_PKT, 16'd0, 8'd171, 8'd77, 32'd0, 64'd0, 64'd0, 16'd0);

        // random phases over register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(CFG_MAGIC, (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF : 8'($urandom));
            write_reg(CFG_INIT_TAG, (ph == 1) ? 8'hFF : (ph == 2) ? 8'h00 : 8'($urandom));
            write_reg(CFG_SW_MODE, {7'd0, ph[0]});
            tag = 8'($urandom);
            for (int n = 0; n < 200; n++)
            begin
                if ($urandom_range(0, 60) == 0) tag = 8'($urandom);
                random_word(tag);
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
